// File: sv/bsa_pkg.sv
// Constants, codes and helpers shared by the slot allocator files.
// No dependencies.
package bsa_pkg;

    // table geometry
    localparam int BUCKET_BITS      = 10;
    localparam int SLOTS_PER_BUCKET = 8;
    localparam int NUM_BUCKETS      = 1 << BUCKET_BITS;
    localparam int SLOT_BITS        = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

    // field widths
    localparam int KEY_W   = 64;
    localparam int IDX_W   = 14;
    localparam int COUNT_W = 14;

    localparam logic [IDX_W-1:0] TABLE_SLOTS = IDX_W'(NUM_BUCKETS * SLOTS_PER_BUCKET);

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    typedef logic [BUCKET_BITS-1:0]      bucket_t;
    typedef logic [SLOTS_PER_BUCKET-1:0] occ_word_t;
    typedef logic [SLOT_BITS-1:0]        slot_t;

    // lowest clear bit of a bucket word; only meaningful when the word is not full
    function automatic slot_t lowest_free(input occ_word_t word);
        slot_t s;
        s = '0;
        for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                s = SLOT_BITS'(i);
            end
        end
        return s;
    endfunction

endpackage

// File: sv/bsa_req_if.sv
// Request channel of the slot allocator: valid/ready with one request word.
// Depends on bsa_pkg.
interface bsa_req_if;
    import bsa_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] slot_index;

    modport source (output valid, func, key, slot_index, input ready);
    modport sink   (input valid, func, key, slot_index, output ready);
endinterface

// File: sv/bsa_rsp_if.sv
// Response channel of the slot allocator: valid/ready with one result word.
// Depends on bsa_pkg.
interface bsa_rsp_if;
    import bsa_pkg::*;

    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   result_slot;
    logic               overflow;
    logic [COUNT_W-1:0] occupied_count;

    modport source (output valid, result_slot, overflow, occupied_count, input ready);
    modport sink   (input valid, result_slot, overflow, occupied_count, output ready);
endinterface

// File: sv/bucketed_slot_allocator_unit.sv
// Slot allocator for a bucketed hash table: occupancy memory, pipeline and count.
// Depends on bsa_pkg, bsa_req_if and bsa_rsp_if.
//
// Usage:
//   req carries one word per operation: func selects insert (claim the lowest
//   free slot in the bucket given by the low key bits) or delete (free the slot
//   given by its flat index). rsp returns one word per request: the claimed
//   slot index (table size on delete or overflow), the overflow flag and the
//   occupied count after the operation.
//   Each taken request word is registered in the read stage, then its result
//   in the result register. Throughput: one word per cycle unless stalled; each
//   operation is one read-modify-write of a bucket word in a single-port-read,
//   single-port-write occupancy RAM with a registered read. The last written
//   word is forwarded, so back-to-back operations on one bucket keep full rate.
//   Reset: a clearing pass writes every bucket word to zero, one per cycle,
//   after rst_n is released; req.ready stays low meanwhile.
//   Stall: when rsp.ready is low with a result held, the result register holds,
//   a loaded read stage holds and so keeps req.ready low until the result is taken.
module bucketed_slot_allocator_unit (
    input  logic      clk,
    input  logic      rst_n,
    bsa_req_if.sink   req,
    bsa_rsp_if.source rsp
);
    import bsa_pkg::*;

    // occupancy memory
    occ_word_t occ_mem [NUM_BUCKETS];

    // clearing pass
    logic    clr_active_reg;
    bucket_t clr_addr_reg;

    // read stage
    logic    s1_valid_reg;
    logic    s1_func_reg;
    bucket_t s1_bucket_reg;
    slot_t   s1_slot_reg;
    logic    s1_del_ok_reg;
    occ_word_t rd_data_reg;

    // last write, for forwarding
    logic      wr_valid_reg;
    bucket_t   wr_bucket_reg;
    occ_word_t wr_word_reg;

    // count and result register
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_slot_reg;
    logic [IDX_W-1:0]   out_slot_next;
    logic               out_ovf_reg;
    logic               out_ovf_next;

    logic      accept;
    logic      s1_fire;
    logic      out_free;
    bucket_t   rd_bucket;
    slot_t     rd_slot;
    logic      rd_del_ok;
    occ_word_t cur_word;
    occ_word_t new_word;
    slot_t     free_slot;
    logic      bucket_full;
    logic      ins_ok;
    logic      del_hit;

    // handshake
    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign req.ready = !clr_active_reg && (!s1_valid_reg || out_free);
    assign accept    = req.valid && req.ready;

    // request decode; slots per bucket is a power of two so the split is a shift
    always_comb
    begin
        rd_del_ok = req.slot_index < TABLE_SLOTS;
        rd_slot   = req.slot_index[SLOT_BITS-1:0];
        if (req.func == FUNC_INSERT)
        begin
            rd_bucket = req.key[BUCKET_BITS-1:0];
        end
        else
        begin
            rd_bucket = BUCKET_BITS'(req.slot_index >> SLOT_BITS);
        end
    end

    // bucket word with forwarding of the last write
    always_comb
    begin
        if (wr_valid_reg && (wr_bucket_reg == s1_bucket_reg))
        begin
            cur_word = wr_word_reg;
        end
        else
        begin
            cur_word = rd_data_reg;
        end
    end

    // modify
    always_comb
    begin
        free_slot     = lowest_free(cur_word);
        bucket_full   = &cur_word;
        ins_ok        = (s1_func_reg == FUNC_INSERT) && !bucket_full;
        del_hit       = (s1_func_reg == FUNC_DELETE) && s1_del_ok_reg && cur_word[s1_slot_reg];
        new_word      = cur_word;
        count_next    = count_reg;
        out_slot_next = TABLE_SLOTS;
        out_ovf_next  = 1'b0;
        if (s1_func_reg == FUNC_INSERT)
        begin
            if (bucket_full)
            begin
                out_ovf_next = 1'b1;
            end
            else
            begin
                new_word[free_slot] = 1'b1;
                count_next          = count_reg + COUNT_W'(1);
                out_slot_next       = IDX_W'({s1_bucket_reg, free_slot});
            end
        end
        else if (del_hit)
        begin
            new_word[s1_slot_reg] = 1'b0;
            if (count_reg != '0)
            begin
                count_next = count_reg - COUNT_W'(1);
            end
        end
    end

    // memory: one read port, one write port shared by clearing and write-back
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= occ_mem[rd_bucket];
        end
        if (clr_active_reg)
        begin
            occ_mem[clr_addr_reg] <= '0;
        end
        else if (s1_fire)
        begin
            occ_mem[s1_bucket_reg] <= new_word;
        end
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + BUCKET_BITS'(1);
            if (&clr_addr_reg)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // read stage payload, last write and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg   <= req.func;
            s1_bucket_reg <= rd_bucket;
            s1_slot_reg   <= rd_slot;
            s1_del_ok_reg <= rd_del_ok;
        end
        if (s1_fire)
        begin
            wr_bucket_reg <= s1_bucket_reg;
            wr_word_reg   <= new_word;
        end
        if (s1_fire)
        begin
            out_slot_reg  <= out_slot_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    // control state and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            wr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                wr_valid_reg  <= 1'b1;
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result channel
    assign rsp.valid          = out_valid_reg;
    assign rsp.result_slot    = out_slot_reg;
    assign rsp.overflow       = out_ovf_reg;
    assign rsp.occupied_count = count_reg;

    // checks
    a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !req.ready)
        else $error("request taken during clearing pass");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(TABLE_SLOTS))
        else $error("occupied count beyond table size");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && ins_ok) |=> (count_reg == $past(count_reg) + COUNT_W'(1)))
        else $error("successful insert did not raise the count");

    a_result_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (rsp.valid && (rsp.occupied_count == $past(count_next))))
        else $error("result word count mismatch");

endmodule
